[rtl/bthp_pkg.sv]
// Shared types, constants and helpers for the beam threshold prune block.
package bthp_pkg;

  // Flips the sign bit so signed sums order as unsigned keys
  localparam logic [31:0] KEY_FLIP = 32'h8000_0000;

  // Register map
  localparam logic REG_BEAM_WIDTH = 1'b0;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SELECT,
    ST_EMIT
  } st_t;

  // Radix-select unit states
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCAN,
    SEL_DECIDE
  } sel_state_t;

  // Saturating signed 32-bit add
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    begin
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
        sat_add32 = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        sat_add32 = s[31:0];
      end
    end
  endfunction

endpackage

[rtl/bthp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bthp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/bthp_radix_sel.sv]
// Radix select: finds the k-th largest stored sum, one key bit per pass over the store.
module bthp_radix_sel #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic [$clog2(MAX_CANDIDATES+1)-1:0] n,
  input  logic [$clog2(MAX_CANDIDATES+1)-1:0] k,
  output logic [$clog2(MAX_CANDIDATES)-1:0]   rd_addr,
  input  logic [31:0]                        rd_data,
  output logic                               done,
  output logic [31:0]                        thr
);

  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int AW = $clog2(MAX_CANDIDATES);

  bthp_pkg::sel_state_t st_r, st_nxt;

  logic [CW-1:0] n_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] a_r;
  logic          rv_r;
  logic [4:0]    bit_r;
  logic [31:0]   pre_r;
  logic          done_r;

  logic          issue;
  logic          scan_end;
  logic [31:0]   key;
  logic [31:0]   above;
  logic          match;

  // Compare unit: key matches the prefix above the current bit and has that bit set
  always_comb begin
    key   = rd_data ^ bthp_pkg::KEY_FLIP;
    above = 32'hFFFF_FFFF << ({1'b0, bit_r} + 6'd1);
    match = (((key ^ pre_r) & above) == 32'h0) && key[bit_r];
  end

  // Control outputs
  always_comb begin
    issue    = (st_r == bthp_pkg::SEL_SCAN) && (a_r != n_r);
    scan_end = (st_r == bthp_pkg::SEL_SCAN) && (a_r == n_r) && !rv_r;
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bthp_pkg::SEL_IDLE:   if (go) st_nxt = bthp_pkg::SEL_SCAN;
      bthp_pkg::SEL_SCAN:   if (scan_end) st_nxt = bthp_pkg::SEL_DECIDE;
      bthp_pkg::SEL_DECIDE: st_nxt = (bit_r == 5'd0) ? bthp_pkg::SEL_IDLE : bthp_pkg::SEL_SCAN;
      default:              st_nxt = bthp_pkg::SEL_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= bthp_pkg::SEL_IDLE;
      rv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rv_r   <= issue;
      done_r <= (st_r == bthp_pkg::SEL_DECIDE) && (bit_r == 5'd0);
    end
  end

  // Datapath: issue reads, count matches, settle one bit per pass
  always_ff @(posedge clk) begin
    unique case (st_r)
      bthp_pkg::SEL_IDLE: begin
        if (go) begin
          n_r   <= n;
          k_r   <= k;
          cnt_r <= '0;
          a_r   <= '0;
          bit_r <= 5'd31;
          pre_r <= 32'h0;
        end
      end
      bthp_pkg::SEL_SCAN: begin
        if (issue) begin
          a_r <= a_r + CW'(1);
        end
        if (rv_r && match) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      bthp_pkg::SEL_DECIDE: begin
        if (cnt_r >= k_r) begin
          pre_r[bit_r] <= 1'b1;
        end else begin
          k_r <= k_r - cnt_r;
        end
        cnt_r <= '0;
        a_r   <= '0;
        if (bit_r != 5'd0) begin
          bit_r <= bit_r - 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = a_r[AW-1:0];
  assign done    = done_r;
  assign thr     = pre_r ^ bthp_pkg::KEY_FLIP;

endmodule

[rtl/beam_threshold_prune.sv]
// Top level: candidate load, threshold select and emission of kept/pruned candidates.
//
//  channel   handshake                     beat contents
//  --------  ----------------------------  ------------------------------------------
//  input     start / busy                  in_cand_index, in_cand_score,
//                                          in_prefix_score, in_last_in
//  result    out_valid (one-cycle strobe)  out_index, out_total_score, out_keep,
//                                          out_threshold_valid, out_threshold, out_last_out
//  config    APB psel/penable/pwrite       beam_width at byte address 0
//
// Loading accepts one candidate per cycle; busy stays low until a beat with in_last_in.
// Threshold select makes 32 passes over the n stored sums in the sum RAM, one key bit
// each, through the single RAM read port and compare unit.
// Select is skipped when no pruning applies. Emission then gives n beats, one a cycle.
// Reset clears the count, state and beam_width; the RAMs need no clearing.
// The result side cannot stall: each beat is on the ports for exactly one cycle.
module beam_threshold_prune #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_cand_index,
  input  logic [31:0] in_cand_score,
  input  logic [31:0] in_prefix_score,
  input  logic        in_last_in,
  // Result channel
  output logic        out_valid,
  output logic [15:0] out_index,
  output logic [31:0] out_total_score,
  output logic        out_keep,
  output logic        out_threshold_valid,
  output logic [31:0] out_threshold,
  output logic        out_last_out,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int AW = $clog2(MAX_CANDIDATES);

  bthp_pkg::st_t st_r, st_nxt;

  logic [6:0]    beam_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] e_r;
  logic          rv_r;
  logic          lastf_r;
  logic          vld_r;
  logic [31:0]   thr_r;

  logic          accept;
  logic          full;
  logic [CW-1:0] n_nxt;
  logic          vld_nxt;
  logic          sel_go;
  logic          sel_done;
  logic [AW-1:0] sel_addr;
  logic [31:0]   sel_thr;
  logic          emit_issue;
  logic          emit_final;
  logic [AW-1:0] sum_raddr;
  logic [31:0]   sum_rdata;
  logic [15:0]   idx_rdata;
  logic          cfg_wr;

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bthp_pkg::REG_BEAM_WIDTH) ? {25'h0, beam_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_r <= 7'd0;
    end else if (cfg_wr && (paddr[2] == bthp_pkg::REG_BEAM_WIDTH)) begin
      beam_r <= pwdata[6:0];
    end
  end

  // Load-side decode
  always_comb begin
    accept  = start && !busy;
    full    = (cnt_r == CW'(MAX_CANDIDATES));
    n_nxt   = full ? cnt_r : cnt_r + CW'(1);
    vld_nxt = (beam_r != 7'd0) && ({1'b0, 8'(n_nxt)} > {2'b0, beam_r});
    sel_go  = accept && in_last_in && vld_nxt;
  end

  // Emission control
  always_comb begin
    emit_issue = (st_r == bthp_pkg::ST_EMIT);
    emit_final = emit_issue && (e_r == n_r - CW'(1));
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bthp_pkg::ST_LOAD: begin
        if (accept && in_last_in) begin
          st_nxt = vld_nxt ? bthp_pkg::ST_SELECT : bthp_pkg::ST_EMIT;
        end
      end
      bthp_pkg::ST_SELECT: if (sel_done) st_nxt = bthp_pkg::ST_EMIT;
      bthp_pkg::ST_EMIT:   if (emit_final) st_nxt = bthp_pkg::ST_LOAD;
      default:             st_nxt = bthp_pkg::ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= bthp_pkg::ST_LOAD;
      cnt_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= emit_issue;
      if (emit_final) begin
        cnt_r <= '0;
      end else if (accept && !full) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // Set bookkeeping and emission address
  always_ff @(posedge clk) begin
    if (accept && in_last_in) begin
      n_r   <= n_nxt;
      vld_r <= vld_nxt;
      e_r   <= '0;
    end else if (emit_issue) begin
      e_r <= e_r + CW'(1);
    end
    lastf_r <= emit_final;
    if (sel_done) begin
      thr_r <= sel_thr;
    end
  end

  // Candidate stores
  assign sum_raddr = (st_r == bthp_pkg::ST_SELECT) ? sel_addr : e_r[AW-1:0];

  bthp_ram #(
    .WIDTH (32),
    .DEPTH (MAX_CANDIDATES)
  ) u_sum_ram (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (cnt_r[AW-1:0]),
    .wdata (bthp_pkg::sat_add32(in_cand_score, in_prefix_score)),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  bthp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CANDIDATES)
  ) u_idx_ram (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_cand_index),
    .raddr (e_r[AW-1:0]),
    .rdata (idx_rdata)
  );

  // Threshold select unit
  bthp_radix_sel #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (sel_go),
    .n       (n_nxt),
    .k       (CW'(beam_r)),
    .rd_addr (sel_addr),
    .rd_data (sum_rdata),
    .done    (sel_done),
    .thr     (sel_thr)
  );

  // Result beat
  assign busy                = (st_r != bthp_pkg::ST_LOAD);
  assign out_valid           = rv_r;
  assign out_index           = idx_rdata;
  assign out_total_score     = sum_rdata;
  assign out_keep            = !vld_r || ($signed(sum_rdata) >= $signed(thr_r));
  assign out_threshold_valid = vld_r;
  assign out_threshold       = vld_r ? thr_r : 32'h0;
  assign out_last_out        = lastf_r;

endmodule

[test/beam_threshold_prune_checker.sv]
// Checker for beam_threshold_prune: predicts every emitted candidate and compares it.
module beam_threshold_prune_checker (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_cand_index,
  input  logic [31:0] in_cand_score,
  input  logic [31:0] in_prefix_score,
  input  logic        in_last_in,
  // result channel
  input  logic        out_valid,
  input  logic [15:0] out_index,
  input  logic [31:0] out_total_score,
  input  logic        out_keep,
  input  logic        out_threshold_valid,
  input  logic [31:0] out_threshold,
  input  logic        out_last_out,
  // register writes
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // status to the top
  output int          fail_count,
  output int          due_count
);

  localparam int SLOTS = 64;
  localparam logic [2:0] BEAM_ADDR = {bthp_pkg::REG_BEAM_WIDTH, 2'b00};
  localparam longint SUM_MAX = 64'sh7FFF_FFFF;
  localparam longint SUM_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic [15:0] index;
    logic [31:0] total;
    logic        keep;
    logic        thr_valid;
    logic [31:0] thr;
    logic        last;
  } cand_beat_t;

  logic [31:0] sum_mem [SLOTS];
  logic [15:0] id_mem  [SLOTS];
  int          held = 0;
  logic [6:0]  beam_w = '0;
  cand_beat_t  due_results [$];
  int          fails = 0;
  int          shown = 0;

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  // Q16.16 add, clamped to the signed 32-bit range
  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > SUM_MAX) return 32'h7FFF_FFFF;
    if (s < SUM_MIN) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // k-th largest of the first n held sums, k = 1 being the largest
  function automatic logic [31:0] rank_sum(input int n, input int k);
    int ranked [SLOTS];
    int v;
    int j;
    for (int i = 0; i < n; i++) begin
      v = $signed(sum_mem[i]);
      j = i;
      // insertion sort, descending
      while (j > 0 && ranked[j-1] < v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    return ranked[k-1];
  endfunction

  task automatic report(input string what, input cand_beat_t want, input cand_beat_t got);
    fails++;
    if (shown < 10) begin
      shown++;
      $display("%0t: %s: expected idx=%h sum=%h keep=%b tv=%b thr=%h last=%b",
               $time, what, want.index, want.total, want.keep, want.thr_valid,
               want.thr, want.last);
      $display("      got      idx=%h sum=%h keep=%b tv=%b thr=%h last=%b",
               got.index, got.total, got.keep, got.thr_valid, got.thr, got.last);
    end
  endtask

  always @(posedge clk) begin : watch
    cand_beat_t  got;
    cand_beat_t  want;
    logic [31:0] s;
    logic [31:0] thr;
    logic        prune;
    if (!rst_n) begin
      held   = 0;
      beam_w = '0;
      due_results.delete();
    end else begin
      // result beat against the oldest due one
      if (out_valid === 1'b1) begin
        got = {out_index, out_total_score, out_keep, out_threshold_valid,
               out_threshold, out_last_out};
        if (due_results.size() == 0) begin
          report("result beat with none due", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.index !== want.index || got.total !== want.total ||
              got.keep !== want.keep || got.thr_valid !== want.thr_valid ||
              got.thr !== want.thr || got.last !== want.last) begin
            report("result beat mismatch", want, got);
          end
        end
      end

      // beam width register write
      if (psel && penable && pwrite && pready && paddr == BEAM_ADDR) begin
        beam_w = pwdata[6:0];
      end

      // accepted candidate beat; a full store drops it
      if (start && !busy) begin
        s = sat_sum(in_cand_score, in_prefix_score);
        if (held < SLOTS) begin
          sum_mem[held] = s;
          id_mem[held]  = in_cand_index;
          held++;
        end
        if (in_last_in) begin
          prune = (beam_w != 0) && (held > int'(beam_w));
          thr   = prune ? rank_sum(held, int'(beam_w)) : '0;
          for (int i = 0; i < held; i++) begin
            want.index     = id_mem[i];
            want.total     = sum_mem[i];
            want.keep      = !prune || ($signed(sum_mem[i]) >= $signed(thr));
            want.thr_valid = prune;
            want.thr       = thr;
            want.last      = (i == held - 1);
            due_results = {due_results, want};
          end
          held = 0;
        end
      end
    end
    fail_count <= fails;
    due_count  <= due_results.size();
  end

endmodule

[test/tb.sv]
// Testbench top for beam_threshold_prune: drives candidate sets and the beam width register.
module tb;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_AFTER  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [2:0] BEAM_ADDR = {bthp_pkg::REG_BEAM_WIDTH, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_cand_index = '0;
  logic [31:0] in_cand_score = '0;
  logic [31:0] in_prefix_score = '0;
  logic        in_last_in = 1'b0;
  logic        out_valid;
  logic [15:0] out_index;
  logic [31:0] out_total_score;
  logic        out_keep;
  logic        out_threshold_valid;
  logic [31:0] out_threshold;
  logic        out_last_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int due_count;
  int rand_sent = 0;
  bit quiet = 1'b0;
  int cycles = 0;

  beam_threshold_prune dut (
    .clk, .rst_n,
    .start, .busy, .in_cand_index, .in_cand_score, .in_prefix_score, .in_last_in,
    .out_valid, .out_index, .out_total_score, .out_keep, .out_threshold_valid,
    .out_threshold, .out_last_out,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  beam_threshold_prune_checker chk (
    .clk, .rst_n,
    .start, .busy, .in_cand_index, .in_cand_score, .in_prefix_score, .in_last_in,
    .out_valid, .out_index, .out_total_score, .out_keep, .out_threshold_valid,
    .out_threshold, .out_last_out,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .due_count
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("beam_threshold_prune test failed");
    $finish;
  end

  // setup then access; the write lands on the edge with pready high
  task automatic write_beam(input logic [6:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BEAM_ADDR;
    pwdata  <= {25'b0, w};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // holds one beat on the input until accepted; start stays high afterwards
  task automatic send_cand(input logic [15:0] idx, input logic [31:0] cs,
                           input logic [31:0] ps, input logic last);
    start           <= 1'b1;
    in_cand_index   <= idx;
    in_cand_score   <= cs;
    in_prefix_score <= ps;
    in_last_in      <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // block idle, every due result in
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (due_count != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // full range, a small tie pool, extremes, small values, zero
  function automatic logic [31:0] pick_score();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        v = int'($urandom_range(0, 6)) - 3;
        return 32'(v) << 16;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h7FFF_0000;
          default: return 32'h8000_0001;
        endcase
      end
      8: begin
        v = int'($urandom_range(0, 255)) - 128;
        return 32'(v);
      end
      default: return '0;
    endcase
  endfunction

  task automatic send_set(input int n);
    logic [31:0] ps;
    for (int i = 0; i < n; i++) begin
      ps = ($urandom_range(0, 9) < 3) ? 32'h0 : pick_score();
      send_cand(16'($urandom), pick_score(), ps, i == n - 1);
      rand_sent++;
      quiet = (rand_sent >= QUIET_AFTER);
      if (!quiet && $urandom_range(0, 5) == 0) rest($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    logic [6:0] w;
    int n;
    int sets;
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // beam width still at its reset value: all kept, sums saturate both ways
    send_cand(16'h0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_cand(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_cand(16'h1234, 32'h0001_0000, 32'h0000_0000, 1'b1);
    drain();

    // lone candidate, then a tie at the top with a beam of one
    write_beam(7'd1);
    send_cand(16'h0001, 32'hFFFF_0000, 32'h0002_0000, 1'b1);
    send_cand(16'h0010, 32'h0005_0000, 32'h0000_0000, 1'b0);
    send_cand(16'h0011, 32'h0003_0000, 32'h0002_0000, 1'b0);
    send_cand(16'h0012, 32'h0003_0000, 32'h0000_0000, 1'b0);
    send_cand(16'h0013, 32'hFFFF_0000, 32'h0000_0000, 1'b1);
    drain();

    // widest beam: set smaller than the beam
    write_beam(7'd64);
    send_cand(16'h8000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    send_cand(16'h7FFF, 32'h1234_5678, 32'h0000_0000, 1'b0);
    send_cand(16'hAAAA, 32'hEDCB_A988, 32'h5555_5555, 1'b1);
    drain();

    // two saturated tops pin the threshold at the positive limit
    write_beam(7'd2);
    send_cand(16'h0020, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_cand(16'h0021, 32'h4000_0000, 32'h4000_0000, 1'b0);
    send_cand(16'h0022, 32'h7FFF_FFFE, 32'h0000_0000, 1'b0);
    send_cand(16'h0023, 32'h8000_0001, 32'hFFFF_FFFE, 1'b0);
    send_cand(16'h5AA5, 32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();

    // one more than the beam, all sums negative
    write_beam(7'd3);
    send_cand(16'h0030, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
    send_cand(16'h0031, 32'hFFFD_0000, 32'h0000_0000, 1'b0);
    send_cand(16'h0032, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0);
    send_cand(16'h0033, 32'h8000_0000, 32'h0000_0000, 1'b1);
    drain();

    // random sets, one beam width per phase, extremes first
    phase = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case (phase)
        0: w = 7'd64;
        1: w = 7'd0;
        2: w = 7'd1;
        3: w = 7'd63;
        default: w = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 64))
                                                  : 7'($urandom_range(1, 16));
      endcase
      write_beam(w);
      sets = $urandom_range(1, 4);
      for (int s = 0; s < sets; s++) begin
        // sizes: store overflow now and then, around the beam, mostly small
        case ($urandom_range(0, 19))
          0: n = $urandom_range(60, 70);
          1, 2, 3: n = (w == 0) ? 1 : int'(w) - 1 + int'($urandom_range(0, 2));
          default: n = $urandom_range(1, 20);
        endcase
        if (phase == 3 && s == 0) n = 66;
        send_set(n);
      end
      drain();
      phase++;
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("beam_threshold_prune test passed");
    end else begin
      $display("beam_threshold_prune test failed");
    end
    $finish;
  end

endmodule
